FILE: rtl/core/ptev_pkg.sv
// Shared types, constants and helpers of the trajectory evaluator.
`default_nettype none
package ptev_pkg;

  localparam int AXES    = 3;
  localparam int COEFF_W = 32;
  localparam int TIME_W  = 24;
  localparam int ACC_W   = 40;
  localparam int QDEPTH  = 2;

  localparam logic [2:0] ORDER_RESET = 3'd7;
  localparam logic [1:0] AXIS_Z      = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_EVAL,
    CMD_ZERO,
    CMD_DROP
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [3:0]          segment;
    logic [1:0]          axis;
    logic [2:0]          term;
    logic [COEFF_W-1:0]  coeff;
    logic [TIME_W-1:0]   ltime;
    logic [1:0]          deriv;
  } qentry_t;

  // i!/(i-k)!, valid for i >= k
  function automatic logic [7:0] fall_weight(input logic [2:0] i, input logic [1:0] k);
    logic [7:0] w;
    w = 8'd1;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < k) begin
        w = 8'(w * (8'(i) - 8'(j)));
      end
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ptev_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/ptev_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
`default_nettype none
module ptev_front #(
  parameter int MAX_SEGMENTS = 16,
  parameter int NUM_TERMS    = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           req_type_i,
  input  wire logic [3:0]                     segment_i,
  input  wire logic [1:0]                     axis_i,
  input  wire logic [2:0]                     term_index_i,
  input  wire logic [ptev_pkg::COEFF_W-1:0]   coeff_value_i,
  input  wire logic [ptev_pkg::TIME_W-1:0]    local_time_i,
  input  wire logic [1:0]                     deriv_sel_i,
  output logic                                q_valid_o,
  output ptev_pkg::qentry_t                   q_entry_o,
  input  wire logic                           q_pop_i
);

  ptev_pkg::qentry_t entry_q [ptev_pkg::QDEPTH];
  ptev_pkg::qentry_t new_entry;
  logic              wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              seg_ok, accept, push, pop;

  assign seg_ok = 32'(segment_i) < MAX_SEGMENTS;

  always_comb begin
    new_entry.segment = segment_i;
    new_entry.axis    = axis_i;
    new_entry.term    = term_index_i;
    new_entry.coeff   = coeff_value_i;
    new_entry.ltime   = local_time_i;
    new_entry.deriv   = deriv_sel_i;
    if (req_type_i) begin
      new_entry.cmd = seg_ok ? ptev_pkg::CMD_EVAL : ptev_pkg::CMD_ZERO;
    end else if (seg_ok && axis_i <= ptev_pkg::AXIS_Z && 32'(term_index_i) < NUM_TERMS) begin
      new_entry.cmd = ptev_pkg::CMD_WRITE;
    end else begin
      new_entry.cmd = ptev_pkg::CMD_DROP;
    end
  end

  assign in_stall_o = count_q == 2'(ptev_pkg::QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  // drop writes that land outside the store
  assign push       = accept && new_entry.cmd != ptev_pkg::CMD_DROP;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = count_q != 2'd0;
  assign q_entry_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = 2'(count_q + 2'(push) - 2'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ptev_back.sv
// Back end: coefficient store, shared Horner multiply-accumulate and result register.
`default_nettype none
module ptev_back #(
  parameter int MAX_SEGMENTS = 16,
  parameter int NUM_TERMS    = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [2:0]                   poly_order_i,
  input  wire logic                         q_valid_i,
  input  ptev_pkg::qentry_t                 q_entry_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        deriv_echo_o,
  output logic [ptev_pkg::COEFF_W-1:0]      value_x_o,
  output logic [ptev_pkg::COEFF_W-1:0]      value_y_o,
  output logic [ptev_pkg::COEFF_W-1:0]      value_z_o,
  output logic                              saturated_o
);

  localparam int DEPTH  = MAX_SEGMENTS * ptev_pkg::AXES * NUM_TERMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [2:0] TOP_TERM = 3'(NUM_TERMS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD0   = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [3:0] seg,
                                                   input logic [1:0] ax,
                                                   input logic [2:0] term);
    return ADDR_W'((32'(seg) * ptev_pkg::AXES + 32'(ax)) * NUM_TERMS + 32'(term));
  endfunction

  logic [2:0]                 state_q, state_d;
  ptev_pkg::qentry_t          cur_q, cur_d;
  logic [1:0]                 axis_q, axis_d;
  logic [2:0]                 i_q, i_d;
  logic signed [39:0]         acc_q, acc_d;
  logic signed [40:0]         wc_q, wc_d;
  logic signed [44:0]         phi_q, phi_d;
  logic [43:0]                plo_q, plo_d;
  logic [31:0]                val_q [ptev_pkg::AXES];
  logic [31:0]                val_d [ptev_pkg::AXES];
  logic                       sat_q, sat_d;
  logic                       ovalid_q, ovalid_d;
  logic [1:0]                 oderiv_q;
  logic [31:0]                ox_q, oy_q, oz_q;
  logic                       osat_q;
  logic                       load_out;

  logic [2:0]                 order_n;
  logic                       we;
  logic [ADDR_W-1:0]          waddr, raddr;
  logic [31:0]                rdata;
  logic signed [40:0]         wprod;
  logic signed [64:0]         full;
  logic signed [49:0]         sum;
  logic                       sum_ovf;
  logic signed [39:0]         fin_acc;
  logic                       fin_ovf, fin_pos;
  logic [31:0]                fin_val;
  logic                       fin_sat;

  assign order_n = (poly_order_i > TOP_TERM) ? TOP_TERM : poly_order_i;

  assign waddr = store_addr(q_entry_i.segment, q_entry_i.axis, q_entry_i.term);
  assign raddr = store_addr(cur_q.segment, axis_q, i_q);

  ptev_ram #(.WIDTH(ptev_pkg::COEFF_W), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (q_entry_i.coeff),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign wprod = $signed({1'b0, ptev_pkg::fall_weight(i_q, cur_q.deriv)}) * $signed(rdata);
  assign phi_d = $signed(acc_q[39:20]) * $signed({1'b0, cur_q.ltime});
  assign plo_d = acc_q[19:0] * cur_q.ltime;

  // floor(acc * t / 2^16) + w * c
  assign full    = $signed({phi_q, 20'b0}) + $signed({21'b0, plo_q});
  assign sum     = $signed({full[64], full[64:16]}) + $signed({{9{wc_q[40]}}, wc_q});
  assign sum_ovf = !(&sum[49:39] || ~|sum[49:39]);

  // close an axis: sign of the escape on overflow, else clip to 32 bits
  always_comb begin
    fin_acc = (state_q == S_ACC) ? sum[39:0] : wprod[39:0];
    fin_ovf = (state_q == S_ACC) && sum_ovf;
    fin_pos = (state_q == S_ACC) ? !sum[49] : !fin_acc[39];
    if (fin_ovf || !(&fin_acc[39:31] || ~|fin_acc[39:31])) begin
      fin_sat = 1'b1;
      fin_val = fin_pos ? VMAX : VMIN;
    end else begin
      fin_sat = 1'b0;
      fin_val = fin_acc[31:0];
    end
  end

  assign load_out = (state_q == S_DONE) && !ovalid_q;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    axis_d   = axis_q;
    i_d      = i_q;
    acc_d    = acc_q;
    wc_d     = wc_q;
    val_d    = val_q;
    sat_d    = sat_q;
    we       = 1'b0;
    q_pop_o  = 1'b0;
    ovalid_d = ovalid_q && out_stall_i;
    if (load_out) begin
      ovalid_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
          axis_d  = 2'd0;
          i_d     = order_n;
          sat_d   = 1'b0;
          for (int a = 0; a < ptev_pkg::AXES; a++) begin
            val_d[a] = '0;
          end
          unique case (q_entry_i.cmd)
            ptev_pkg::CMD_WRITE: we = 1'b1;
            ptev_pkg::CMD_EVAL:  state_d = (3'(q_entry_i.deriv) > order_n) ? S_DONE : S_RD0;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_RD0: state_d = S_FIRST;
      S_FIRST: begin
        acc_d = wprod[39:0];
        if (i_q == 3'(cur_q.deriv)) begin
          val_d[axis_q] = fin_val;
          sat_d         = sat_q | fin_sat;
          axis_d        = 2'(axis_q + 2'd1);
          i_d           = order_n;
          state_d       = (axis_q == ptev_pkg::AXIS_Z) ? S_DONE : S_RD0;
        end else begin
          i_d     = 3'(i_q - 3'd1);
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_MUL;
      S_MUL: begin
        wc_d    = wprod;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = sum[39:0];
        if (sum_ovf || i_q == 3'(cur_q.deriv)) begin
          val_d[axis_q] = fin_val;
          sat_d         = sat_q | fin_sat;
          axis_d        = 2'(axis_q + 2'd1);
          i_d           = order_n;
          state_d       = (axis_q == ptev_pkg::AXIS_Z) ? S_DONE : S_RD0;
        end else begin
          i_d     = 3'(i_q - 3'd1);
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!ovalid_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    axis_q <= axis_d;
    i_q    <= i_d;
    acc_q  <= acc_d;
    wc_q   <= wc_d;
    phi_q  <= phi_d;
    plo_q  <= plo_d;
    val_q  <= val_d;
    sat_q  <= sat_d;
    if (load_out) begin
      oderiv_q <= cur_q.deriv;
      ox_q     <= val_q[0];
      oy_q     <= val_q[1];
      oz_q     <= val_q[2];
      osat_q   <= sat_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign deriv_echo_o = oderiv_q;
  assign value_x_o    = ox_q;
  assign value_y_o    = oy_q;
  assign value_z_o    = oz_q;
  assign saturated_o  = osat_q;

endmodule
`default_nettype wire

FILE: rtl/core/polynomial_trajectory_evaluator_unit.sv
// A coefficient write is queued, then stored when the engine, once idle, takes it from the queue.
// An evaluate steps the terms of each axis in turn, from order n down to derivative k (n order,
// k derivative), through the single shared multiply-accumulate; when k > n it returns zeros.
// Up to two further requests are queued while one is evaluated; results leave one at a time.
// Reset: control and the order register (to 7) clear asynchronously; coefficients are
// undefined until written.
`default_nettype none
module polynomial_trajectory_evaluator_unit #(
  parameter int MAX_SEGMENTS = 16,
  parameter int NUM_TERMS    = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         req_type_i,
  input  wire logic [3:0]                   segment_i,
  input  wire logic [1:0]                   axis_i,
  input  wire logic [2:0]                   term_index_i,
  input  wire logic signed [31:0]           coeff_value_i,
  input  wire logic [23:0]                  local_time_i,
  input  wire logic [1:0]                   deriv_sel_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        deriv_echo_o,
  output logic signed [31:0]                value_x_o,
  output logic signed [31:0]                value_y_o,
  output logic signed [31:0]                value_z_o,
  output logic                              saturated_o
);

  logic [2:0]        order_q;
  logic              q_valid, q_pop;
  ptev_pkg::qentry_t q_entry;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, order_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ptev_pkg::ORDER_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      order_q <= pwdata[2:0];
    end
  end

  ptev_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .NUM_TERMS(NUM_TERMS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .segment_i     (segment_i),
    .axis_i        (axis_i),
    .term_index_i  (term_index_i),
    .coeff_value_i (coeff_value_i),
    .local_time_i  (local_time_i),
    .deriv_sel_i   (deriv_sel_i),
    .q_valid_o     (q_valid),
    .q_entry_o     (q_entry),
    .q_pop_i       (q_pop)
  );

  ptev_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .NUM_TERMS(NUM_TERMS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .poly_order_i (order_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .deriv_echo_o (deriv_echo_o),
    .value_x_o    (value_x_o),
    .value_y_o    (value_y_o),
    .value_z_o    (value_z_o),
    .saturated_o  (saturated_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/ptev_checker.sv
// Port-level checks of the trajectory evaluator, bound to the top level.
`default_nettype none
module ptev_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  deriv_echo_o,
  input wire logic [31:0] value_x_o,
  input wire logic [31:0] value_y_o,
  input wire logic [31:0] value_z_o,
  input wire logic        saturated_o
);

  localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VMIN = 32'h8000_0000;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({deriv_echo_o, value_x_o, value_y_o,
                                            value_z_o, saturated_o}))
    else $error("result changed while stalled");

  // a clipped transaction must carry a full-scale component
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> value_x_o == VMAX || value_x_o == VMIN ||
      value_y_o == VMAX || value_y_o == VMIN || value_z_o == VMAX || value_z_o == VMIN)
    else $error("saturated flag without a clipped value");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind polynomial_trajectory_evaluator_unit ptev_checker u_ptev_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pready       (pready),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .deriv_echo_o (deriv_echo_o),
  .value_x_o    (value_x_o),
  .value_y_o    (value_y_o),
  .value_z_o    (value_z_o),
  .saturated_o  (saturated_o)
);
`default_nettype wire

FILE: sim/ptev_checker.sv
// Scoreboard for the trajectory evaluator: mirrors coefficients and order, checks each result.
`timescale 1ns / 100ps
module ptev_scoreboard (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic [2:0]         paddr_i,
  input  wire logic [31:0]        pwdata_i,
  input  wire logic               pready_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic               req_type_i,
  input  wire logic [3:0]         segment_i,
  input  wire logic [1:0]         axis_i,
  input  wire logic [2:0]         term_index_i,
  input  wire logic signed [31:0] coeff_value_i,
  input  wire logic [23:0]        local_time_i,
  input  wire logic [1:0]         deriv_sel_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [1:0]         deriv_echo_i,
  input  wire logic signed [31:0] value_x_i,
  input  wire logic signed [31:0] value_y_i,
  input  wire logic signed [31:0] value_z_i,
  input  wire logic               saturated_i,
  output int                      errors_o,
  output int                      pending_o
);

  localparam logic [2:0] ADDR_ORDER = 3'd0;
  localparam longint     ACC_HI = 64'sd549755813887;
  localparam longint     ACC_LO = -64'sd549755813888;

  typedef struct {
    logic [1:0]         deriv;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               sat;
  } sample_t;

  logic signed [31:0] coeff_mirror [16*ptev_pkg::AXES*8];
  logic [2:0]         order_mirror;
  sample_t            setpoint_q [$];

  function automatic longint weight(int i, int k);
    longint w;
    w = 1;
    for (int j = 0; j < k; j++) w = w * (i - j);
    return w;
  endfunction

  function automatic logic signed [31:0] horner(int base, int n, int k, longint t,
                                                inout logic sat);
    longint acc;
    if (k > n) return 32'sd0;
    acc = weight(n, k) * longint'(coeff_mirror[base + n]);
    for (int i = n - 1; i >= k; i--) begin
      acc = ((acc * t) >>> 16) + weight(i, k) * longint'(coeff_mirror[base + i]);
      // overflow pins the axis regardless of later terms
      if (acc > ACC_HI) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      if (acc < ACC_LO) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
    end
    if (acc > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (acc < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return acc[31:0];
  endfunction

  function automatic sample_t evaluate(int seg, int k, longint t);
    sample_t s;
    logic    sat;
    int      n;
    sat = 1'b0;
    n = order_mirror;
    s.deriv = k[1:0];
    s.vx = horner((seg * ptev_pkg::AXES + 0) * 8, n, k, t, sat);
    s.vy = horner((seg * ptev_pkg::AXES + 1) * 8, n, k, t, sat);
    s.vz = horner((seg * ptev_pkg::AXES + 2) * 8, n, k, t, sat);
    s.sat = sat;
    return s;
  endfunction

  always @(posedge clk_i) begin
    sample_t want;
    if (!rst_ni) begin
      order_mirror = ptev_pkg::ORDER_RESET;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_ORDER)
        order_mirror = pwdata_i[2:0];
      if (out_valid_i && !out_stall_i) begin
        if (setpoint_q.size() == 0) begin
          $display("%0t: unexpected result deriv=%0d x=%0d y=%0d z=%0d sat=%0d", $time,
                   deriv_echo_i, value_x_i, value_y_i, value_z_i, saturated_i);
          errors_o++;
        end else begin
          want = setpoint_q.pop_front();
          if (deriv_echo_i !== want.deriv || value_x_i !== want.vx || value_y_i !== want.vy
              || value_z_i !== want.vz || saturated_i !== want.sat) begin
            $display("%0t: mismatch expected deriv=%0d x=%0d y=%0d z=%0d sat=%0d", $time,
                     want.deriv, want.vx, want.vy, want.vz, want.sat);
            $display("%0t:          actual   deriv=%0d x=%0d y=%0d z=%0d sat=%0d", $time,
                     deriv_echo_i, value_x_i, value_y_i, value_z_i, saturated_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i) begin
          setpoint_q.push_back(evaluate(segment_i, deriv_sel_i, longint'(local_time_i)));
        end else if (axis_i != 2'd3) begin
          coeff_mirror[(segment_i * ptev_pkg::AXES + axis_i) * 8 + term_index_i] = coeff_value_i;
        end
      end
      pending_o <= setpoint_q.size();
    end
  end

  final begin
    if (setpoint_q.size() != 0) $display("%0t: %0d results never arrived", $time,
                                         setpoint_q.size());
  end
endmodule

FILE: sim/testbench.sv
// Top of the trajectory evaluator bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 100;
  localparam logic [2:0] ADDR_ORDER = 3'd0;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [3:0] segment_i = '0;
  logic [1:0] axis_i = '0;
  logic [2:0] term_index_i = '0;
  logic signed [31:0] coeff_value_i = '0;
  logic [23:0] local_time_i = '0;
  logic [1:0] deriv_sel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] deriv_echo_o;
  logic signed [31:0] value_x_o, value_y_o, value_z_o;
  logic saturated_o;
  int errors, pending, cycles = 0;
  int idle_pct = 0, stall_pct = 0;

  polynomial_trajectory_evaluator_unit dut (.*);

  ptev_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .in_valid_i, .in_stall_i(in_stall_o), .req_type_i,
    .segment_i, .axis_i, .term_index_i, .coeff_value_i, .local_time_i, .deriv_sel_i,
    .out_valid_i(out_valid_o), .out_stall_i, .deriv_echo_i(deriv_echo_o),
    .value_x_i(value_x_o), .value_y_i(value_y_o), .value_z_i(value_z_o),
    .saturated_i(saturated_o), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // entered and left just after a falling edge
  task automatic push_req(logic req, logic [3:0] seg, logic [1:0] ax, logic [2:0] term,
                          logic [31:0] coeff, logic [23:0] t, logic [1:0] k);
    logic stalled;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    segment_i <= seg;
    axis_i <= ax;
    term_index_i <= term;
    coeff_value_i <= coeff;
    local_time_i <= t;
    deriv_sel_i <= k;
    // stall only moves at a rising edge, so the low phase shows what that edge sees
    stalled = in_stall_o;
    @(negedge clk_i);
    while (stalled) begin
      stalled = in_stall_o;
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic set_order(logic [2:0] order);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_ORDER;
    pwdata <= {$urandom_range(1) ? 29'h1fffffff : 29'h0, order};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic logic [23:0] rand_time();
    case ($urandom_range(7))
      0: return 24'hffffff;
      1: return 24'h0;
      2: return 24'($urandom);
      default: return 24'($urandom_range(98304));
    endcase
  endfunction

  task automatic random_req();
    if ($urandom_range(99) < 55)
      push_req(REQ_EVAL, 4'($urandom), 2'($urandom), 3'($urandom), $urandom, rand_time(),
               2'($urandom));
    else
      push_req(REQ_WRITE, 4'($urandom), $urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2)),
               3'($urandom), rand_coeff(), 24'($urandom), 2'($urandom));
  endtask

  initial begin
    logic [2:0] orders [6] = '{3'd7, 3'd1, 3'd0, 3'd4, 3'd7, 3'd2};
    int pct [4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{14, 14}};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill every coefficient so no evaluate reads an unwritten entry
    for (int s = 0; s < 16; s++)
      for (int a = 0; a < ptev_pkg::AXES; a++)
        for (int i = 0; i < 8; i++)
          push_req(REQ_WRITE, 4'(s), 2'(a), 3'(i), rand_coeff(), 24'($urandom), 2'($urandom));

    // directed: extremes, each derivative, ignored axis, saturation, order below derivative
    for (int k = 0; k < 4; k++) push_req(REQ_EVAL, 4'd0, 2'd0, 3'd0, '0, 24'h010000, 2'(k));
    push_req(REQ_EVAL, 4'd15, 2'd3, 3'd7, 32'hffffffff, 24'h000000, 2'd0);
    push_req(REQ_EVAL, 4'd15, 2'd0, 3'd0, '0, 24'hffffff, 2'd0);
    for (int i = 0; i < 8; i++)
      push_req(REQ_WRITE, 4'd15, 2'd0, 3'(i), 32'h7fffffff, '0, '0);
    push_req(REQ_WRITE, 4'd15, 2'd1, 3'd7, 32'h80000000, 24'hffffff, 2'd3);
    push_req(REQ_WRITE, 4'd15, 2'd3, 3'd0, 32'h12345678, '0, '0);
    push_req(REQ_EVAL, 4'd15, 2'd0, 3'd0, '0, 24'hffffff, 2'd0);
    push_req(REQ_EVAL, 4'd15, 2'd0, 3'd0, '0, 24'hffffff, 2'd3);
    set_order(3'd1);
    push_req(REQ_EVAL, 4'd15, 2'd0, 3'd0, '0, 24'h018000, 2'd3);
    push_req(REQ_EVAL, 4'd3, 2'd0, 3'd0, '0, 24'h018000, 2'd1);
    set_order(3'd0);
    push_req(REQ_EVAL, 4'd3, 2'd0, 3'd0, '0, 24'h018000, 2'd0);
    push_req(REQ_EVAL, 4'd3, 2'd0, 3'd0, '0, 24'h018000, 2'd1);

    for (int ph = 0; ph < 6; ph++) begin
      set_order(orders[ph]);
      idle_pct = pct[ph % 4][0];
      stall_pct = pct[ph % 4][1];
      for (int n = 0; n < 35; n++) begin
        random_req();
        // let everything in flight come out before carrying on
        if (ph == 1 && n == 17) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/ptev_pkg.sv
rtl/core/ptev_ram.sv
rtl/core/ptev_front.sv
rtl/core/ptev_back.sv
rtl/core/polynomial_trajectory_evaluator_unit.sv
rtl/core/ptev_checker.sv
sim/ptev_checker.sv
sim/testbench.sv
